// ===== hdl/assert_macros.svh =====
// Assertion helpers for the frustum visibility block.
// Each macro takes a label, the clock, the active-low reset, an antecedent
// and a consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define QFV_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qfv assertion failed");
// Next-cycle implication
`define QFV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qfv assertion failed");
`else
`define QFV_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define QFV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/qfv_pkg.sv =====
`timescale 1ns / 1ps

package qfv_pkg;

    // Defaults for the top-level parameters
    localparam int COORD_BITS_DEF  = 16;
    localparam int NUM_CORNERS_DEF = 4;

    // Plane register layout
    localparam int PLANE_COUNT = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int NORM_W      = 16;
    // Q8.8 offset is aligned to the Q.22 product scale
    localparam int OFF_SHIFT   = 14;

    // Result codes
    typedef enum logic [1:0] {
        VIS_OUTSIDE = 2'd0,
        VIS_INSIDE  = 2'd1,
        VIS_PARTIAL = 2'd2
    } vis_t;

    // One unpacked plane
    typedef struct packed {
        logic signed [NORM_W-1:0] off;
        logic signed [NORM_W-1:0] nz;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nx;
    } plane_t;

    // Stage enables that travel down the pipeline together
    typedef struct packed {
        logic en;
    } pipe_ctl_t;

    function automatic plane_t unpack_plane(input logic [CFG_DATA_W-1:0] raw);
        plane_t p;
        p.nx  = raw[15:0];
        p.ny  = raw[31:16];
        p.nz  = raw[47:32];
        p.off = raw[63:48];
        return p;
    endfunction

endpackage

// ===== hdl/qfv_plane_test.sv =====
`timescale 1ns / 1ps

// One corner against one plane: multiply, partial sums, final sum and sign.
module qfv_plane_test #(
    parameter int COORD_BITS = qfv_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  qfv_pkg::pipe_ctl_t           ctl,
    input  qfv_pkg::plane_t              plane,
    input  logic signed [COORD_BITS-1:0] x,
    input  logic signed [COORD_BITS-1:0] y,
    input  logic signed [COORD_BITS-1:0] z,
    output logic                         plane_ok
);

    localparam int PROD_W = COORD_BITS + qfv_pkg::NORM_W;
    localparam int OFF_W  = qfv_pkg::NORM_W + qfv_pkg::OFF_SHIFT;
    localparam int SUM_W  = ((PROD_W > OFF_W) ? PROD_W : OFF_W) + 2;

    logic signed [PROD_W-1:0]         px_reg, py_reg, pz_reg;
    logic signed [PROD_W-1:0]         px_next, py_next, pz_next;
    logic signed [qfv_pkg::NORM_W-1:0] off_reg;
    logic signed [SUM_W-1:0]          sxy_reg, szo_reg, sxy_next, szo_next;
    logic signed [SUM_W-1:0]          total;
    logic                             inside_reg, inside_next;

    // Stage 1: products, exact in Q10.22
    assign px_next = PROD_W'(plane.nx) * PROD_W'(x);
    assign py_next = PROD_W'(plane.ny) * PROD_W'(y);
    assign pz_next = PROD_W'(plane.nz) * PROD_W'(z);

    // Stage 2: pairwise sums, offset aligned to the product scale
    assign sxy_next = SUM_W'(px_reg) + SUM_W'(py_reg);
    assign szo_next = SUM_W'(pz_reg) + (SUM_W'(off_reg) <<< qfv_pkg::OFF_SHIFT);

    // Stage 3: final sum; zero counts as inside
    assign total       = sxy_reg + szo_reg;
    assign inside_next = ~total[SUM_W-1];

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            px_reg     <= px_next;
            py_reg     <= py_next;
            pz_reg     <= pz_next;
            off_reg    <= plane.off;
            sxy_reg    <= sxy_next;
            szo_reg    <= szo_next;
            inside_reg <= inside_next;
        end
    end

    assign plane_ok = inside_reg;

endmodule

// ===== hdl/qfv_classify.sv =====
`timescale 1ns / 1ps

// Stage 4: combine plane tests per corner and classify the quad.
module qfv_classify #(
    parameter int NUM_CORNERS = qfv_pkg::NUM_CORNERS_DEF
) (
    input  logic                                          clk,
    input  qfv_pkg::pipe_ctl_t                            ctl,
    // bit c*PLANE_COUNT+p: corner c passes plane p
    input  logic [NUM_CORNERS*qfv_pkg::PLANE_COUNT-1:0]   plane_ok,
    output qfv_pkg::vis_t                                 vis
);

    logic [NUM_CORNERS-1:0] corner_in;
    qfv_pkg::vis_t          vis_reg, vis_next;

    // A corner is inside when every plane agrees
    always_comb
    begin
        for (int c = 0; c < NUM_CORNERS; c++)
        begin
            corner_in[c] = &plane_ok[c*qfv_pkg::PLANE_COUNT +: qfv_pkg::PLANE_COUNT];
        end
    end

    always_comb
    begin
        priority if (&corner_in)
            vis_next = qfv_pkg::VIS_INSIDE;
        else if (corner_in == '0)
            vis_next = qfv_pkg::VIS_OUTSIDE;
        else
            vis_next = qfv_pkg::VIS_PARTIAL;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            vis_reg <= vis_next;
        end
    end

    assign vis = vis_reg;

endmodule

// ===== hdl/quad_frustum_visibility.sv =====
`timescale 1ns / 1ps

// Pipeline from input transaction to m_tvalid: multiply, pair add, final
// add and sign, classify. Throughput: one quad per cycle, set by the
// per-corner, per-plane lane pipeline; a stall on m_tready freezes all stages.
// Reset: all six planes clear to zero (every quad then reads as inside) and
// the pipeline empties; payload registers are not reset.
module quad_frustum_visibility #(
    parameter int COORD_BITS  = qfv_pkg::COORD_BITS_DEF,
    parameter int NUM_CORNERS = qfv_pkg::NUM_CORNERS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input quad
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // corner0_x, corner0_y, corner0_z, corner1_x, ... (COORD_BITS each), zero pad
    input  logic [((3*NUM_CORNERS*COORD_BITS+7)/8)*8-1:0] s_tdata,
    // Result
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // visibility [1:0], zero pad
    output logic [7:0]                       m_tdata,
    // Plane registers
    input  logic                             cfg_we,
    input  logic [qfv_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [qfv_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    `include "assert_macros.svh"

    localparam int LANES = NUM_CORNERS * qfv_pkg::PLANE_COUNT;

    logic [qfv_pkg::CFG_DATA_W-1:0] planes_reg [qfv_pkg::PLANE_COUNT];
    logic [3:0]                     vld_reg, vld_next;
    qfv_pkg::pipe_ctl_t             ctl;
    logic [LANES-1:0]               plane_ok;
    qfv_pkg::vis_t                  vis;

    // Plane register writes; indexes past the last plane are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < qfv_pkg::PLANE_COUNT; p++)
            begin
                planes_reg[p] <= '0;
            end
        end
        else if (cfg_we && (32'(cfg_addr) < qfv_pkg::PLANE_COUNT))
        begin
            planes_reg[cfg_addr] <= cfg_wdata;
        end
    end

    // Whole pipeline advances together unless the output is held
    assign ctl.en   = !vld_reg[3] || m_tready;
    assign s_tready = ctl.en;
    assign vld_next = ctl.en ? {vld_reg[2:0], s_tvalid} : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // One lane per corner and plane
    for (genvar c = 0; c < NUM_CORNERS; c++)
    begin : g_corner
        for (genvar p = 0; p < qfv_pkg::PLANE_COUNT; p++)
        begin : g_plane
            qfv_plane_test #(
                .COORD_BITS (COORD_BITS)
            ) u_test (
                .clk      (clk),
                .ctl      (ctl),
                .plane    (qfv_pkg::unpack_plane(planes_reg[p])),
                .x        (s_tdata[(3*c+0)*COORD_BITS +: COORD_BITS]),
                .y        (s_tdata[(3*c+1)*COORD_BITS +: COORD_BITS]),
                .z        (s_tdata[(3*c+2)*COORD_BITS +: COORD_BITS]),
                .plane_ok (plane_ok[c*qfv_pkg::PLANE_COUNT + p])
            );
        end
    end

    qfv_classify #(
        .NUM_CORNERS (NUM_CORNERS)
    ) u_classify (
        .clk      (clk),
        .ctl      (ctl),
        .plane_ok (plane_ok),
        .vis      (vis)
    );

    assign m_tvalid = vld_reg[3];
    assign m_tdata  = {6'b0, vis};

    // Checks
    `QFV_ASSERT_IMPLY(a_vis_code, clk, rst_n, m_tvalid, m_tdata[1:0] != 2'd3)
    `QFV_ASSERT_NEXT(a_accept_enters, clk, rst_n, s_tvalid && s_tready, vld_reg[0])
    `QFV_ASSERT_NEXT(a_last_stage_out, clk, rst_n, vld_reg[2] && ctl.en, m_tvalid)

endmodule

// ===== tb/tb_quad_frustum_visibility.sv =====
`timescale 1ns / 1ps

module tb_quad_frustum_visibility;

    import qfv_pkg::*;

    localparam int NCORNERS   = NUM_CORNERS_DEF;
    localparam int CBITS      = COORD_BITS_DEF;
    localparam int SDATA_W    = ((3 * NCORNERS * CBITS + 7) / 8) * 8;
    localparam int LATENCY    = 4;
    localparam int STALL_LIMIT = 2000;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 120;
    localparam int MAX_REPORTS = 20;
    localparam int ONE_Q14    = 16384;

    // Plane register indexes
    localparam int IDX_NEAR   = 0;
    localparam int IDX_FAR    = 1;
    localparam int IDX_LEFT   = 2;
    localparam int IDX_RIGHT  = 3;
    localparam int IDX_TOP    = 4;
    localparam int IDX_BOTTOM = 5;

    // Expected visibility per quad, with a mirror of the plane registers
    class vis_scoreboard;
        plane_t planes[PLANE_COUNT];
        vis_t   expected_vis[$];
        int     errors;

        function new();
            int i;
            for (i = 0; i < PLANE_COUNT; i++)
                planes[i] = '0;
            errors = 0;
        endfunction

        function void write_plane(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            // indexes past the last plane are dropped by the block
            if (idx < PLANE_COUNT)
                planes[idx] = plane_t'(val);
        endfunction

        function bit corner_inside(logic signed [CBITS-1:0] cx, logic signed [CBITS-1:0] cy,
                                   logic signed [CBITS-1:0] cz);
            longint plane_dist;
            int     p;
            for (p = 0; p < PLANE_COUNT; p++)
            begin
                plane_dist = longint'($signed(planes[p].nx)) * longint'(cx)
                           + longint'($signed(planes[p].ny)) * longint'(cy)
                           + longint'($signed(planes[p].nz)) * longint'(cz)
                           + longint'($signed(planes[p].off)) * (longint'(1) << OFF_SHIFT);
                if (plane_dist < 0)
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function vis_t classify_quad(logic [SDATA_W-1:0] d);
            int n_inside;
            int c;
            n_inside = 0;
            for (c = 0; c < NCORNERS; c++)
            begin
                if (corner_inside(d[(3*c)*CBITS +: CBITS], d[(3*c+1)*CBITS +: CBITS],
                                  d[(3*c+2)*CBITS +: CBITS]))
                    n_inside++;
            end
            if (n_inside == NCORNERS)
                return VIS_INSIDE;
            else if (n_inside == 0)
                return VIS_OUTSIDE;
            return VIS_PARTIAL;
        endfunction

        function void note_quad(logic [SDATA_W-1:0] d);
            expected_vis.push_back(classify_quad(d));
        endfunction

        function void check_visibility(logic [7:0] got);
            vis_t want;
            if (expected_vis.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result transaction, actual %0d", $time, got);
            end
            else
            begin
                want = expected_vis.pop_front();
                if (got !== {6'd0, want})
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: visibility mismatch, expected %0d, actual %0d",
                                 $time, want, got);
                end
            end
        endfunction

        function int pending();
            return expected_vis.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    // corner0_x, corner0_y, corner0_z, corner1_x, ... corner3_z
    logic [SDATA_W-1:0]   s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    // visibility [1:0], zero pad
    logic [7:0]           m_tdata;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    vis_scoreboard sb;
    int send_idle  = 0;
    int recv_stall = 0;
    int quiet_cycles = 0;

    // Box extent used to aim quads at the current planes
    int box_half = 1024;
    int box_near = 256;
    int box_far  = 4096;

    quad_frustum_visibility uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver backpressure
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall);

    // Monitor: mirror config writes, predict accepted quads, check results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                sb.write_plane(cfg_addr, cfg_wdata);
            if (s_tvalid && s_tready)
                sb.note_quad(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_visibility(m_tdata);
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL quad_frustum_visibility");
            $finish;
        end
    end

    function automatic logic [CBITS-1:0] clamp16(int v);
        if (v > 32767)
            return 16'h7fff;
        if (v < -32768)
            return 16'h8000;
        return v[CBITS-1:0];
    endfunction

    function automatic int jitter(int amt);
        if (amt == 0)
            return 0;
        return int'($urandom_range(0, 2 * amt)) - amt;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] plane_word(int nx, int ny, int nz, int off);
        return {clamp16(off), clamp16(nz), clamp16(ny), clamp16(nx)};
    endfunction

    // Square quad in the z plane: (x,y), (x+d,y), (x,y+d), (x+d,y+d)
    function automatic logic [SDATA_W-1:0] square_quad(int x, int y, int z, int d);
        logic [SDATA_W-1:0] q;
        int c;
        q = '0;
        for (c = 0; c < NCORNERS; c++)
        begin
            q[(3*c)*CBITS +: CBITS]   = clamp16(x + ((c % 2) ? d : 0));
            q[(3*c+1)*CBITS +: CBITS] = clamp16(y + ((c / 2) ? d : 0));
            q[(3*c+2)*CBITS +: CBITS] = clamp16(z);
        end
        return q;
    endfunction

    function automatic logic [CBITS-1:0] edge_coord();
        case ($urandom_range(4))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return CBITS'($urandom);
        endcase
    endfunction

    // Mostly quads clustered around the box, some noise and field extremes
    function automatic logic [SDATA_W-1:0] random_quad();
        logic [SDATA_W-1:0] q;
        int kind, cx, cy, cz, spread, depth, k;
        kind = $urandom_range(99);
        q = '0;
        if (kind < 60)
        begin
            depth  = box_far - box_near;
            cx     = int'($urandom_range(0, 3 * box_half)) - (3 * box_half) / 2;
            cy     = int'($urandom_range(0, 3 * box_half)) - (3 * box_half) / 2;
            cz     = box_near - depth / 4 + int'($urandom_range(0, depth + depth / 2));
            spread = $urandom_range(0, box_half / 2 + 1);
            for (k = 0; k < NCORNERS; k++)
            begin
                q[(3*k)*CBITS +: CBITS]   = clamp16(cx + jitter(spread));
                q[(3*k+1)*CBITS +: CBITS] = clamp16(cy + jitter(spread));
                q[(3*k+2)*CBITS +: CBITS] = clamp16(cz + jitter(spread));
            end
        end
        else if (kind < 85)
        begin
            for (k = 0; k < SDATA_W / 32; k++)
                q[32*k +: 32] = $urandom;
        end
        else
        begin
            for (k = 0; k < 3 * NCORNERS; k++)
                q[k*CBITS +: CBITS] = edge_coord();
        end
        return q;
    endfunction

    task automatic send_quad(input logic [SDATA_W-1:0] q);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= q;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Stop sending and let the pipeline drain before touching the planes
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_reg(input int idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx[CFG_IDX_W-1:0];
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic end_writes();
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_all(input logic [CFG_DATA_W-1:0] val);
        int i;
        for (i = 0; i < PLANE_COUNT; i++)
            write_reg(i, val);
        end_writes();
    endtask

    // Axis-aligned box |x|,|y| <= b, zn <= z <= zf, normals optionally tilted
    task automatic write_box(input int b, input int zn, input int zf, input int jit);
        box_half = b;
        box_near = zn;
        box_far  = zf;
        write_reg(IDX_NEAR,   plane_word(jitter(jit), jitter(jit), ONE_Q14 + jitter(jit), -zn));
        write_reg(IDX_FAR,    plane_word(jitter(jit), jitter(jit), -ONE_Q14 + jitter(jit), zf));
        write_reg(IDX_LEFT,   plane_word(ONE_Q14 + jitter(jit), jitter(jit), jitter(jit), b));
        write_reg(IDX_RIGHT,  plane_word(-ONE_Q14 + jitter(jit), jitter(jit), jitter(jit), b));
        write_reg(IDX_TOP,    plane_word(jitter(jit), -ONE_Q14 + jitter(jit), jitter(jit), b));
        write_reg(IDX_BOTTOM, plane_word(jitter(jit), ONE_Q14 + jitter(jit), jitter(jit), b));
        end_writes();
    endtask

    initial
    begin
        int ph, i, zn;
        sb = new();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Planes at reset: everything reads as inside
        send_quad('0);
        send_quad('1);
        send_quad(square_quad(-32768, -32768, -32768, 0));
        send_quad(square_quad(32767, 32767, 32767, 0));

        // Box planes, plus writes past the last plane that must be dropped
        settle();
        write_box(1024, 256, 4096, 0);
        write_reg(PLANE_COUNT, {$urandom, $urandom});
        write_reg(PLANE_COUNT + 1, '1);
        end_writes();
        send_quad(square_quad(-100, -100, 1000, 200));
        send_quad(square_quad(2000, 2000, 1000, 100));
        send_quad(square_quad(1000, 0, 1000, 100));
        // corners lying exactly on the right, top and near planes
        send_quad(square_quad(924, 924, 256, 100));
        send_quad(square_quad(1025, 0, 1000, 0));
        send_quad(square_quad(0, 0, 255, 0));
        send_quad(square_quad(32767, 32767, 32767, 0));
        send_quad(square_quad(-32768, -32768, -32768, 32767));

        // Zero normals: only the sign of the offset matters
        settle();
        write_all(plane_word(0, 0, 0, -1));
        send_quad(square_quad(0, 0, 1000, 10));
        settle();
        write_all(plane_word(0, 0, 0, 32767));
        send_quad(square_quad(-32768, 32767, 0, 1));

        // Extreme register contents
        settle();
        write_all('1);
        send_quad(square_quad(-32768, -32768, -32768, 0));
        send_quad(square_quad(32767, 32767, 32767, 0));
        settle();
        write_all(64'h8000_8000_8000_8000);
        send_quad(square_quad(-32768, -32768, -32768, 0));
        send_quad(square_quad(0, 0, -20000, 10000));
        settle();
        write_all(64'h7fff_7fff_7fff_7fff);
        send_quad(square_quad(32767, 32767, 32767, 0));
        send_quad(square_quad(-32768, -32768, -32768, 32767));

        // Random phases over plane sets and handshake pressure
        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            settle();
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 49; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 49; end
                default: begin send_idle = 23; recv_stall = 23; end
            endcase
            zn = int'($urandom_range(0, 2000)) - 1000;
            case (ph % 3)
                0: write_box($urandom_range(128, 12000), zn,
                             zn + int'($urandom_range(256, 16000)), 0);
                1: write_box($urandom_range(128, 12000), zn,
                             zn + int'($urandom_range(256, 16000)),
                             $urandom_range(500, 4000));
                default:
                begin
                    box_half = $urandom_range(64, 20000);
                    box_near = -box_half;
                    box_far  = box_half;
                    for (i = 0; i < PLANE_COUNT + 2; i++)
                        write_reg(i, {$urandom, $urandom});
                    end_writes();
                end
            endcase
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                // sender holds off until everything in flight has come out
                if (ph == 5 && i == PHASE_ITEMS / 2)
                begin
                    s_tvalid <= 1'b0;
                    while (sb.pending() != 0)
                        @(posedge clk);
                end
                send_quad(random_quad());
            end
        end

        settle();
        if (sb.errors == 0)
            $display("PASS quad_frustum_visibility");
        else
            $display("FAIL quad_frustum_visibility");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/qfv_pkg.sv
hdl/qfv_plane_test.sv
hdl/qfv_classify.sv
hdl/quad_frustum_visibility.sv
tb/tb_quad_frustum_visibility.sv
